// ----- rtl/tts_pkg.sv -----
package tts_pkg;

  localparam int TASK_SLOTS = 8;
  localparam int COUNT_BITS = 16;
  localparam int SLOT_BITS  = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_DELETE  = 3'd1,
    OP_SUSPEND = 3'd2,
    OP_RESUME  = 3'd3,
    OP_TICK    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_BUSY  = 2'd2
  } status_t;

  // microprogram addresses
  typedef enum logic [2:0] {
    S_WAIT   = 3'd0,
    S_DECODE = 3'd1,
    S_CREATE = 3'd2,
    S_DELETE = 3'd3,
    S_FLAG   = 3'd4,
    S_TICK   = 3'd5,
    S_RESP   = 3'd6
  } step_t;

  typedef enum logic [2:0] {
    A_LATCH,
    A_DECODE,
    A_CREATE,
    A_DELETE,
    A_FLAG,
    A_TICK,
    A_RESP
  } action_t;

  typedef enum logic [2:0] {
    C_ACCEPT,  // hold until a request is taken
    C_OP,      // dispatch on operation
    C_JUMP,
    C_LOOP,    // back to target until last slot
    C_OUT      // hold until the output register is free
  } cond_t;

  typedef struct packed {
    action_t action;
    cond_t   cond;
    step_t   target;
    logic    in_ready;
  } uword_t;

  typedef struct packed {
    logic       accept;
    logic [2:0] operation;
    logic       slot_ok;
    logic       last;
    logic       out_free;
  } seq_flags_t;

  typedef struct packed {
    step_t   step;
    action_t action;
    logic    in_ready;
  } ctrl_t;

  function automatic uword_t urom(step_t addr);
    uword_t w;
    case (addr)
      S_WAIT:   w = '{action: A_LATCH,  cond: C_ACCEPT, target: S_WAIT, in_ready: 1'b1};
      S_DECODE: w = '{action: A_DECODE, cond: C_OP,     target: S_WAIT, in_ready: 1'b0};
      S_CREATE: w = '{action: A_CREATE, cond: C_JUMP,   target: S_RESP, in_ready: 1'b0};
      S_DELETE: w = '{action: A_DELETE, cond: C_JUMP,   target: S_RESP, in_ready: 1'b0};
      S_FLAG:   w = '{action: A_FLAG,   cond: C_JUMP,   target: S_RESP, in_ready: 1'b0};
      S_TICK:   w = '{action: A_TICK,   cond: C_LOOP,   target: S_TICK, in_ready: 1'b0};
      S_RESP:   w = '{action: A_RESP,   cond: C_OUT,    target: S_WAIT, in_ready: 1'b0};
      default:  w = '{action: A_LATCH,  cond: C_JUMP,   target: S_WAIT, in_ready: 1'b0};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/tts_if.sv -----
interface tts_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [3:0]  slot;
  logic [15:0] period;
  logic [15:0] first_delay;
  logic        start_ready;

  modport source (output valid, operation, slot, period, first_delay, start_ready,
                  input ready);
  modport sink (input valid, operation, slot, period, first_delay, start_ready,
                output ready);
endinterface

interface tts_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] fired_mask;

  modport source (output valid, status, fired_mask, input ready);
  modport sink (input valid, status, fired_mask, output ready);
endinterface

// ----- rtl/periodic_task_tick_scheduler.sv -----
// channel | dir | payload
// req     | in  | operation, slot, period, first_delay, start_ready
// rsp     | out | status, fired_mask
//
// A command runs through the decode step, its command step and the response step that loads the result register.
// An out-of-range slot or an unused operation goes from decode straight to the response step.
// A tick walks all TASK_SLOTS slots, one slot per cycle through the shared update, before the response step.
// The microprogram sequencer accepts one request at a time; req.ready is low during reset.
// Synchronous reset clears the task table, sequencer and output valid.
// A stalled result holds the sequencer in its response step.
module periodic_task_tick_scheduler (
  input logic clk,
  input logic rst,
  tts_req_if.sink   req,
  tts_rsp_if.source rsp
);
  import tts_pkg::*;

  localparam int CB = COUNT_BITS;
  localparam int SB = SLOT_BITS;

  ctrl_t      ctrl;
  seq_flags_t flags;

  logic [2:0]      req_op;
  logic [3:0]      req_slot;
  logic [CB-1:0]   req_period;
  logic [CB-1:0]   req_delay;
  logic            req_rdy;

  logic [SB-1:0]         idx;
  status_t               status;
  logic [TASK_SLOTS-1:0] fired;

  logic [CB-1:0] period_store    [TASK_SLOTS];
  logic [CB-1:0] countdown_store [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] ready_flags;

  logic       out_valid;
  status_t    out_status;
  logic [7:0] out_fired;

  logic          accept;
  logic          slot_ok;
  logic          last;
  logic          out_free;
  logic [CB-1:0] cur_per;
  logic [CB-1:0] cur_cnt;
  logic [CB-1:0] dec;
  logic          active;

  tts_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  assign accept   = req.valid && req.ready;
  assign slot_ok  = ({1'b0, req_slot} < 5'(TASK_SLOTS));
  assign last     = (idx == SB'(TASK_SLOTS - 1));
  assign out_free = !out_valid || rsp.ready;
  assign flags    = '{accept: accept, operation: req_op, slot_ok: slot_ok,
                      last: last, out_free: out_free};

  assign req.ready = ctrl.in_ready && !rst;

  assign cur_per = period_store[idx];
  assign cur_cnt = countdown_store[idx];
  assign dec     = cur_cnt - CB'(1);
  assign active  = (cur_per != '0) && ready_flags[idx];

  always_ff @(posedge clk) begin
    case (ctrl.action)
      A_LATCH: begin
        if (accept) begin
          req_op     <= req.operation;
          req_slot   <= req.slot;
          req_period <= CB'(req.period);
          req_delay  <= CB'(req.first_delay);
          req_rdy    <= req.start_ready;
        end
      end
      A_DECODE: begin
        fired <= '0;
        if (req_op == OP_TICK) begin
          idx <= '0;
        end else begin
          idx <= req_slot[SB-1:0];
        end
        if ((req_op inside {OP_CREATE, OP_DELETE, OP_SUSPEND, OP_RESUME}) && !slot_ok) begin
          status <= ST_RANGE;
        end else begin
          status <= ST_OK;
        end
      end
      A_CREATE: begin
        if (cur_per != '0) status <= ST_BUSY;
      end
      A_TICK: begin
        if (active && dec == '0) fired[idx] <= 1'b1;
        if (!last) idx <= idx + SB'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        period_store[i]    <= '0;
        countdown_store[i] <= '0;
      end
      ready_flags <= '0;
    end else begin
      case (ctrl.action)
        A_CREATE: begin
          if (cur_per == '0) begin
            period_store[idx]    <= req_period;
            countdown_store[idx] <= (req_delay == '0) ? CB'(1) : req_delay;
            ready_flags[idx]     <= req_rdy;
          end
        end
        A_DELETE: period_store[idx] <= '0;
        A_FLAG:   ready_flags[idx] <= (req_op == OP_RESUME);
        A_TICK: begin
          if (active) countdown_store[idx] <= (dec == '0) ? cur_per : dec;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.action == A_RESP && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.action == A_RESP && out_free) begin
      out_status <= status;
      out_fired  <= 8'(fired);
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.fired_mask = out_fired;

  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (ctrl.step == S_DECODE))
    else $error("accepted request not decoded");

  a_tick_walk: assert property (@(posedge clk) disable iff (rst)
    (ctrl.step == S_TICK && !last) |=> (ctrl.step == S_TICK && idx == $past(idx) + SB'(1)))
    else $error("tick walk skipped a slot");

  a_fire_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.fired_mask == 8'd0 || rsp.status == ST_OK))
    else $error("fired mask with error status");

  a_busy_pc: assert property (@(posedge clk) disable iff (rst)
    (ctrl.step == S_RESP && !out_free) |=> (ctrl.step == S_RESP))
    else $error("result dropped while output stalled");

endmodule

// ----- rtl/tts_seq.sv -----
module tts_seq (
  input  logic                clk,
  input  logic                rst,
  input  tts_pkg::seq_flags_t flags,
  output tts_pkg::ctrl_t      ctrl
);
  import tts_pkg::*;

  step_t  pc;
  step_t  pc_next;
  uword_t uw;
  logic   is_cmd;

  assign uw     = urom(pc);
  assign is_cmd = flags.operation inside {OP_CREATE, OP_DELETE, OP_SUSPEND, OP_RESUME};

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    pc_next = pc;
    case (uw.cond)
      C_ACCEPT: begin
        if (flags.accept) pc_next = step_t'(pc + 3'd1);
      end
      C_OP: begin
        if (is_cmd && !flags.slot_ok) begin
          pc_next = S_RESP;
        end else begin
          case (flags.operation)
            OP_CREATE:             pc_next = S_CREATE;
            OP_DELETE:             pc_next = S_DELETE;
            OP_SUSPEND, OP_RESUME: pc_next = S_FLAG;
            OP_TICK:               pc_next = S_TICK;
            default:               pc_next = S_RESP;
          endcase
        end
      end
      C_JUMP: pc_next = uw.target;
      C_LOOP: begin
        pc_next = flags.last ? step_t'(pc + 3'd1) : uw.target;
      end
      C_OUT: begin
        if (flags.out_free) pc_next = uw.target;
      end
      default: pc_next = S_WAIT;
    endcase
  end

  assign ctrl = '{step: pc, action: uw.action, in_ready: uw.in_ready};

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import tts_pkg::*;

  localparam int N_RAND = 1925;
  localparam int PAUSE_AT = 1200;
  localparam int CALM_LO = 700;
  localparam int CALM_HI = 1000;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 250;
  localparam int IDLE_PCT = 19;
  localparam int DRAIN_CYCLES = 24;
  localparam logic [2:0] OP_RSVD_LO = 3'd5;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  operation;
    logic [3:0]  slot;
    logic [15:0] period;
    logic [15:0] first_delay;
    logic        start_ready;
  } sched_cmd_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] fired_mask;
  } sched_rsp_t;

  typedef struct {
    sched_cmd_t cmd;
    bit         typed;
    sched_rsp_t rsp;
  } dir_row_t;

  logic clk;
  logic rst;

  tts_req_if req_ch ();
  tts_rsp_if rsp_ch ();

  periodic_task_tick_scheduler i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  logic [COUNT_BITS-1:0] period_q [TASK_SLOTS];
  logic [COUNT_BITS-1:0] count_q  [TASK_SLOTS];
  logic                  ready_q  [TASK_SLOTS];

  sched_rsp_t exp_rsp_q [$];
  dir_row_t   dir_rows [$];
  int         n_rsp;
  int         n_err;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic sched_rsp_t sched_predict(sched_cmd_t c);
    sched_rsp_t r;
    logic [SLOT_BITS-1:0] s;
    r.status = ST_OK;
    r.fired_mask = '0;
    s = c.slot[SLOT_BITS-1:0];
    case (c.operation)
      OP_CREATE: begin
        if (c.slot >= TASK_SLOTS) begin
          r.status = ST_RANGE;
        end else if (period_q[s] != 0) begin
          r.status = ST_BUSY;
        end else begin
          period_q[s] = c.period[COUNT_BITS-1:0];
          count_q[s] = (c.first_delay[COUNT_BITS-1:0] == 0) ? COUNT_BITS'(1)
                                                            : c.first_delay[COUNT_BITS-1:0];
          ready_q[s] = c.start_ready;
        end
      end
      OP_DELETE: begin
        if (c.slot >= TASK_SLOTS) r.status = ST_RANGE;
        else period_q[s] = '0;
      end
      OP_SUSPEND, OP_RESUME: begin
        if (c.slot >= TASK_SLOTS) r.status = ST_RANGE;
        else ready_q[s] = (c.operation == OP_RESUME);
      end
      OP_TICK: begin
        for (int i = 0; i < TASK_SLOTS; i++) begin
          if (period_q[i] != 0 && ready_q[i]) begin
            count_q[i] = count_q[i] - COUNT_BITS'(1);
            if (count_q[i] == 0) begin
              r.fired_mask[i] = 1'b1;
              count_q[i] = period_q[i];
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void add_row(logic [2:0] op, logic [3:0] slot, logic [15:0] per,
                                  logic [15:0] dly, logic rdy, bit typed,
                                  status_t st, logic [7:0] fm);
    dir_row_t row;
    row.cmd = '{operation: op, slot: slot, period: per, first_delay: dly, start_ready: rdy};
    row.typed = typed;
    row.rsp = '{status: st, fired_mask: fm};
    dir_rows.push_back(row);
  endfunction

  function automatic sched_cmd_t rand_cmd();
    sched_cmd_t c;
    int k;
    int p;
    c.operation = OP_TICK;
    c.slot = 4'($urandom_range(15));
    c.period = 16'($urandom);
    c.first_delay = 16'($urandom);
    c.start_ready = 1'($urandom_range(1));
    k = $urandom_range(99);
    if (k < 38) begin
      c.operation = OP_TICK;
    end else if (k < 90) begin
      if (k < 62) c.operation = OP_CREATE;
      else if (k < 72) c.operation = OP_DELETE;
      else if (k < 80) c.operation = OP_SUSPEND;
      else c.operation = OP_RESUME;
      if ($urandom_range(99) < 88) c.slot = 4'($urandom_range(TASK_SLOTS - 1));
      p = $urandom_range(99);
      if (p < 8) c.period = '0;
      else if (p < 85) c.period = 16'($urandom_range(6, 1));
      p = $urandom_range(99);
      if (p < 10) c.first_delay = '0;
      else if (p < 75) c.first_delay = 16'($urandom_range(6, 1));
      if ($urandom_range(99) < 80) c.start_ready = 1'b1;
    end else if (k < 94) begin
      c.operation = 3'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
    end else begin
      // fully random create, mostly rejected or long-delay
      c.operation = OP_CREATE;
    end
    return c;
  endfunction

  // request side
  initial begin
    sched_cmd_t cmd;
    sched_rsp_t pred;
    int n_total;
    req_ch.valid <= 1'b0;
    req_ch.operation <= OP_TICK;
    req_ch.slot <= '0;
    req_ch.period <= '0;
    req_ch.first_delay <= '0;
    req_ch.start_ready <= 1'b0;
    rst <= 1'b1;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      period_q[i] = '0;
      count_q[i] = '0;
      ready_q[i] = 1'b0;
    end
    n_err = 0;

    add_row(OP_TICK,    4'd0,  16'h0000, 16'h0000, 1'b0, 1'b1, ST_OK,    8'h00);
    add_row(OP_CREATE,  4'd8,  16'h0001, 16'h0001, 1'b1, 1'b1, ST_RANGE, 8'h00);
    add_row(OP_CREATE,  4'd15, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, ST_RANGE, 8'h00);
    add_row(OP_DELETE,  4'd9,  16'h0000, 16'h0000, 1'b0, 1'b1, ST_RANGE, 8'h00);
    add_row(OP_SUSPEND, 4'd12, 16'h0000, 16'h0000, 1'b0, 1'b1, ST_RANGE, 8'h00);
    add_row(OP_RESUME,  4'd15, 16'h0000, 16'h0000, 1'b0, 1'b1, ST_RANGE, 8'h00);
    add_row(OP_CREATE,  4'd0,  16'h0001, 16'h0000, 1'b1, 1'b1, ST_OK,    8'h00);
    add_row(OP_CREATE,  4'd0,  16'h0005, 16'h0003, 1'b1, 1'b1, ST_BUSY,  8'h00);
    add_row(OP_CREATE,  4'd7,  16'hFFFF, 16'hFFFF, 1'b1, 1'b1, ST_OK,    8'h00);
    add_row(OP_CREATE,  4'd3,  16'h0000, 16'h0005, 1'b1, 1'b1, ST_OK,    8'h00);
    add_row(OP_CREATE,  4'd3,  16'h0002, 16'h0000, 1'b0, 1'b0, ST_OK,    8'h00);
    add_row(OP_TICK,    4'd0,  16'h0000, 16'h0000, 1'b0, 1'b1, ST_OK,    8'h01);
    add_row(OP_CREATE,  4'd5,  16'h0002, 16'h0001, 1'b0, 1'b1, ST_OK,    8'h00);
    add_row(OP_RESUME,  4'd5,  16'h0000, 16'h0000, 1'b0, 1'b0, ST_OK,    8'h00);
    add_row(OP_TICK,    4'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, ST_OK,    8'h00);
    add_row(OP_SUSPEND, 4'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, ST_OK,    8'h00);
    add_row(OP_TICK,    4'd0,  16'h0000, 16'h0000, 1'b0, 1'b0, ST_OK,    8'h00);
    add_row(OP_RESUME,  4'd4,  16'h0000, 16'h0000, 1'b0, 1'b0, ST_OK,    8'h00);
    add_row(OP_DELETE,  4'd7,  16'h0000, 16'h0000, 1'b0, 1'b0, ST_OK,    8'h00);
    add_row(OP_DELETE,  4'd6,  16'h0000, 16'h0000, 1'b0, 1'b0, ST_OK,    8'h00);
    add_row(OP_RSVD_LO, 4'd15, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, ST_OK,    8'h00);
    add_row(OP_RSVD_HI, 4'd2,  16'h0003, 16'h0001, 1'b1, 1'b1, ST_OK,    8'h00);
    add_row(OP_TICK,    4'd15, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, ST_OK,    8'h00);
    add_row(OP_CREATE,  4'd1,  16'hAAAA, 16'h5555, 1'b1, 1'b0, ST_OK,    8'h00);
    add_row(OP_CREATE,  4'd2,  16'h5555, 16'hAAAA, 1'b0, 1'b0, ST_OK,    8'h00);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    n_total = dir_rows.size() + N_RAND;
    for (int n = 0; n < n_total; n++) begin
      cmd = (n < dir_rows.size()) ? dir_rows[n].cmd : rand_cmd();
      req_ch.valid <= 1'b1;
      req_ch.operation <= cmd.operation;
      req_ch.slot <= cmd.slot;
      req_ch.period <= cmd.period;
      req_ch.first_delay <= cmd.first_delay;
      req_ch.start_ready <= cmd.start_ready;
      @(posedge clk);
      while (!req_ch.ready) @(posedge clk);
      pred = sched_predict(cmd);
      if (n < dir_rows.size() && dir_rows[n].typed) exp_rsp_q.push_back(dir_rows[n].rsp);
      else exp_rsp_q.push_back(pred);

      if (n == PAUSE_AT) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (exp_rsp_q.size() != 0) @(posedge clk);
      end else if ((n < CALM_LO || n >= CALM_HI) && $urandom_range(99) < IDLE_PCT) begin
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(4, 1)) @(posedge clk);
      end
    end
    req_ch.valid <= 1'b0;

    while (exp_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_err == 0 && exp_rsp_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // response side
  initial begin
    sched_rsp_t want;
    int hold_left;
    bit hold_done;
    rsp_ch.ready <= 1'b0;
    n_rsp = 0;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        if (exp_rsp_q.size() == 0) begin
          $display("%0t: unexpected response status=%0d fired=%02h", $time,
                   rsp_ch.status, rsp_ch.fired_mask);
          n_err++;
        end else begin
          want = exp_rsp_q.pop_front();
          if (rsp_ch.status !== want.status) begin
            $display("%0t: status mismatch exp=%0d act=%0d", $time, want.status,
                     rsp_ch.status);
            n_err++;
          end
          if (rsp_ch.fired_mask !== want.fired_mask) begin
            $display("%0t: fired_mask mismatch exp=%02h act=%02h", $time,
                     want.fired_mask, rsp_ch.fired_mask);
            n_err++;
          end
        end
        n_rsp++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!hold_done && n_rsp == HOLD_AT) begin
        // long back-pressure; the block must stall requests
        hold_done = 1;
        hold_left = HOLD_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else if (n_rsp >= CALM_LO && n_rsp < CALM_HI) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

endmodule
